// ----- rtl/tahc_pkg.sv -----
// Shared types, constants and register codes of the tilt average hysteresis classifier.
package tahc_pkg;

    localparam int SAMPLE_W      = 8;
    localparam int INTERVAL_W    = 16;
    localparam int THRESH_W      = 8;
    localparam int SWING_W       = 2;
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_DATA_W    = 16;
    localparam int WINDOW_LEN_DEF = 6;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd50;
    localparam logic [THRESH_W-1:0]   LEFT_RST     = 8'd95;
    localparam logic [THRESH_W-1:0]   RIGHT_RST    = 8'd70;
    localparam logic [THRESH_W-1:0]   MARGIN_RST   = 8'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN   = 8'd3;

    // Codes driven on the swing state output.
    localparam logic [SWING_W-1:0] SWING_STRAIGHT = 2'd0;
    localparam logic [SWING_W-1:0] SWING_LEFT     = 2'd1;
    localparam logic [SWING_W-1:0] SWING_RIGHT    = 2'd2;

    typedef enum logic [2:0] {
        DIR_STRAIGHT = 3'b001,
        DIR_LEFT     = 3'b010,
        DIR_RIGHT    = 3'b100
    } t_dir;

    // Threshold settings handed to the classifier.
    typedef struct packed {
        logic [THRESH_W-1:0] left;
        logic [THRESH_W-1:0] right;
        logic [THRESH_W-1:0] margin;
    } t_thresh;

    // Update request from the window stage to the classifier stage.
    typedef struct packed {
        logic load;
        logic taken;
    } t_cls_ctrl;

endpackage

// ----- rtl/tahc_cell.sv -----
// One window cell: holds a sample and passes it to its neighbor on each shift.
module tahc_cell
    import tahc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_shift,
    input  logic [SAMPLE_W-1:0] i_d,
    output logic [SAMPLE_W-1:0] o_q
);

    logic [SAMPLE_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

// ----- rtl/tahc_classifier.sv -----
// Averaging divider and hysteresis classifier holding the current average and direction.
module tahc_classifier
    import tahc_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF,
    parameter int SUM_W      = 11
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cls_ctrl           i_ctrl,
    input  logic [SUM_W-1:0]    i_sum,
    input  t_thresh             i_thresh,
    output logic [SWING_W-1:0]  o_swing_state,
    output logic [SAMPLE_W-1:0] o_average_value
);

    // floor(sum / WINDOW_LEN) as a multiply by a rounded-up reciprocal.
    localparam int SHIFT  = SUM_W + $clog2(WINDOW_LEN);
    localparam int PROD_W = SUM_W + SHIFT + 1;
    localparam logic [SHIFT:0] RECIP = (SHIFT+1)'(((1 << SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN);

    logic [PROD_W-1:0]   w_prod;
    logic [SAMPLE_W-1:0] w_avg;
    logic [THRESH_W:0]   w_avg_ext;
    logic [THRESH_W:0]   w_avg_plus_m;
    logic [THRESH_W:0]   w_right_plus_m;
    t_dir                n_dir;
    t_dir                r_dir;
    logic [SAMPLE_W-1:0] r_avg;

    assign w_prod = PROD_W'(i_sum) * PROD_W'(RECIP);
    assign w_avg  = w_prod[SHIFT +: SAMPLE_W];

    // Nine-bit sums keep the return thresholds from wrapping.
    assign w_avg_ext      = {1'b0, w_avg};
    assign w_avg_plus_m   = w_avg_ext + {1'b0, i_thresh.margin};
    assign w_right_plus_m = {1'b0, i_thresh.right} + {1'b0, i_thresh.margin};

    always_comb begin
        n_dir = r_dir;
        unique case (r_dir)
            DIR_STRAIGHT: begin
                if (w_avg > i_thresh.left) begin
                    n_dir = DIR_LEFT;
                end else if (w_avg < i_thresh.right) begin
                    n_dir = DIR_RIGHT;
                end
            end
            DIR_LEFT: begin
                if (w_avg_plus_m < {1'b0, i_thresh.left}) begin
                    n_dir = DIR_STRAIGHT;
                end
            end
            DIR_RIGHT: begin
                if (w_avg_ext > w_right_plus_m) begin
                    n_dir = DIR_STRAIGHT;
                end
            end
            default: begin
                n_dir = DIR_STRAIGHT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= DIR_STRAIGHT;
            r_avg <= '0;
        end else if (i_ctrl.load && i_ctrl.taken) begin
            r_dir <= n_dir;
            r_avg <= w_avg;
        end
    end

    always_comb begin
        unique case (r_dir)
            DIR_LEFT:  o_swing_state = SWING_LEFT;
            DIR_RIGHT: o_swing_state = SWING_RIGHT;
            default:   o_swing_state = SWING_STRAIGHT;
        endcase
    end

    assign o_average_value = r_avg;

endmodule

// ----- rtl/tilt_average_hysteresis_classifier.sv -----
// Top level of the tilt classifier: tick decimation, sample window and output stage.
//
// Each input transaction is one tick carrying a converter sample, and each tick yields
// exactly one output transaction with the current swing state, the current average and
// a flag telling whether this tick took a sample. The block sustains one transaction per
// clock cycle while the output is not stalled. In the window stage the tick countdown is
// checked and, on a sampling tick, the sample is shifted into a row of WINDOW_LEN cells
// while the running sum drops the oldest cell and adds the new sample; in the output stage
// the sum is divided by WINDOW_LEN through a reciprocal multiply and, on a sampling tick,
// the hysteresis classifier updates, landing in the output register. The window stage may
// hold one more transaction while a result waits on a stalled output, so input stall rises
// only when both stages are full and the output is stalled. Configuration writes are always
// ready and take effect at once; writes to indexes beyond the four registers are ignored.
module tilt_average_hysteresis_classifier
    import tahc_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Tick input channel.
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [SAMPLE_W-1:0]   i_sample,
    // Result channel.
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [SWING_W-1:0]    o_swing_state,
    output logic [SAMPLE_W-1:0]   o_average_value,
    output logic                  o_sample_taken,
    // Configuration write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // The sum of a full window of maximum samples sets the accumulator width.
    localparam int SUM_MAX = WINDOW_LEN * ((1 << SAMPLE_W) - 1);
    localparam int SUM_W   = $clog2(SUM_MAX + 1);

    // Configuration registers.
    logic [INTERVAL_W-1:0] r_interval;
    t_thresh               r_thresh;

    // Window stage.
    logic [INTERVAL_W-1:0] r_cnt;
    logic [SUM_W-1:0]      r_sum;
    logic                  r_a_valid;
    logic                  r_a_taken;
    logic [SAMPLE_W-1:0]   w_cell [WINDOW_LEN];
    logic                  w_take;
    logic                  w_accept;

    // Output stage.
    logic                  r_out_valid;
    logic                  r_out_taken;
    logic                  w_a_ready;
    logic                  w_b_ready;
    logic                  w_b_load;
    t_cls_ctrl             w_ctrl;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval      <= INTERVAL_RST;
            r_thresh.left   <= LEFT_RST;
            r_thresh.right  <= RIGHT_RST;
            r_thresh.margin <= MARGIN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_INTERVAL: r_interval      <= i_cfg_data;
                REG_LEFT:     r_thresh.left   <= i_cfg_data[THRESH_W-1:0];
                REG_RIGHT:    r_thresh.right  <= i_cfg_data[THRESH_W-1:0];
                REG_MARGIN:   r_thresh.margin <= i_cfg_data[THRESH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Handshake: each stage advances when the stage after it is empty or moving.
    assign w_b_ready  = !r_out_valid || !i_out_stall;
    assign w_a_ready  = !r_a_valid || w_b_ready;
    assign w_b_load   = r_a_valid && w_b_ready;
    assign w_accept   = i_in_valid && w_a_ready;
    assign o_in_stall = !w_a_ready;

    // A tick samples when the countdown has run down to one or zero; an interval of
    // zero reloads zero, so every following tick samples.
    assign w_take = w_accept && (r_cnt <= INTERVAL_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_sum     <= '0;
            r_a_valid <= 1'b0;
            r_a_taken <= 1'b0;
        end else begin
            if (w_accept) begin
                r_cnt     <= (r_cnt <= INTERVAL_W'(1)) ? r_interval : r_cnt - INTERVAL_W'(1);
                r_a_taken <= (r_cnt <= INTERVAL_W'(1));
            end
            if (w_take) begin
                // The last cell holds the oldest sample, which leaves the window now.
                r_sum <= r_sum - SUM_W'(w_cell[WINDOW_LEN-1]) + SUM_W'(i_sample);
            end
            if (w_a_ready) begin
                r_a_valid <= i_in_valid;
            end
        end
    end

    // Row of window cells, newest at the head.
    for (genvar k = 0; k < WINDOW_LEN; k++) begin : g_cells
        logic [SAMPLE_W-1:0] w_d;
        if (k == 0) begin : g_head
            assign w_d = i_sample;
        end else begin : g_link
            assign w_d = w_cell[k-1];
        end
        tahc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_take),
            .i_d     (w_d),
            .o_q     (w_cell[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_taken <= 1'b0;
        end else begin
            if (w_b_ready) begin
                r_out_valid <= r_a_valid;
            end
            if (w_b_load) begin
                r_out_taken <= r_a_taken;
            end
        end
    end

    assign w_ctrl.load  = w_b_load;
    assign w_ctrl.taken = r_a_taken;

    tahc_classifier #(
        .WINDOW_LEN (WINDOW_LEN),
        .SUM_W      (SUM_W)
    ) u_classifier (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (w_ctrl),
        .i_sum           (r_sum),
        .i_thresh        (r_thresh),
        .o_swing_state   (o_swing_state),
        .o_average_value (o_average_value)
    );

    assign o_out_valid    = r_out_valid;
    assign o_sample_taken = r_out_taken;

    // The running sum never exceeds a window full of maximum samples.
    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum <= SUM_W'(SUM_MAX))
        else $error("window sum out of range");

    // A tick that took no sample leaves the average as it was.
    a_idle_tick_keeps_avg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_b_load && !r_a_taken) |=> $stable(o_average_value))
        else $error("average changed on a tick without a sample");

    // Input stall only rises when both stages are full and the output is held.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_a_valid && r_out_valid && i_out_stall))
        else $error("input stalled with room in the pipeline");

    // The window only shifts on an accepted transaction.
    a_take_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> (i_in_valid && !o_in_stall))
        else $error("window shifted without an accepted transaction");

endmodule
